### design/tar_hsp_pkg.sv
// Shared types, codes and header-layout constants for the tar header stream parser.
// Depends on nothing; imported by tar_header_stream_parser and the testbench.
package tar_hsp_pkg;

  // Field widths of the result item
  localparam int SIZE_BITS   = 36;
  localparam int OFFSET_BITS = 48;
  localparam int IDX_BITS    = 9;

  // Byte positions inside a 512-byte header block
  localparam logic [IDX_BITS-1:0] NAME_END   = 9'd100;
  localparam logic [IDX_BITS-1:0] MODE_BEG   = 9'd100;
  localparam logic [IDX_BITS-1:0] MODE_END   = 9'd108;
  localparam logic [IDX_BITS-1:0] SIZE_BEG   = 9'd124;
  localparam logic [IDX_BITS-1:0] SIZE_END   = 9'd136;
  localparam logic [IDX_BITS-1:0] TYPE_POS   = 9'd156;
  localparam logic [IDX_BITS-1:0] MAGIC_BEG  = 9'd257;
  localparam logic [IDX_BITS-1:0] MAGIC_VER  = 9'd262;
  localparam logic [IDX_BITS-1:0] PREFIX_BEG = 9'd345;
  localparam logic [IDX_BITS-1:0] PREFIX_END = 9'd500;
  localparam logic [IDX_BITS-1:0] LAST_IDX   = 9'd511;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Type flag bytes
  localparam logic [7:0] TF_FILE    = 8'h30;
  localparam logic [7:0] TF_SYMLINK = 8'h32;
  localparam logic [7:0] TF_DIR     = 8'h35;

  // Result kinds
  localparam logic [1:0] KIND_DESC    = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_CORRUPT = 2'd2;

  // Entry types
  localparam logic [1:0] ET_UNKNOWN = 2'd0;
  localparam logic [1:0] ET_FILE    = 2'd1;
  localparam logic [1:0] ET_DIR     = 2'd2;
  localparam logic [1:0] ET_SYMLINK = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_PAD    = 2'd2,
    PH_HALT   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] archive_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             data_byte;
    logic                   last_data;
    logic [1:0]             entry_type;
    logic                   ustar_flag;
    logic [15:0]            mode_bits;
    logic [SIZE_BITS-1:0]   file_size;
    logic [OFFSET_BITS-1:0] data_offset;
    logic [7:0]             name_length;
  } result_t;

  typedef struct packed {
    phase_t                 phase;
    logic [IDX_BITS-1:0]    block_index;
    logic [OFFSET_BITS-1:0] stream_offset;
    logic [SIZE_BITS-1:0]   data_left;
    logic [IDX_BITS-1:0]    pad_left;
    logic                   all_zero;
    logic [15:0]            mode_acc;
    logic                   mode_open;
    logic [SIZE_BITS-1:0]   size_acc;
    logic                   size_open;
    logic                   magic_match;
    logic [7:0]             type_code;
    logic [6:0]             name_len;
    logic [6:0]             name_trail;
    logic                   name_done;
    logic [7:0]             prefix_len;
    logic [7:0]             prefix_trail;
    logic                   prefix_done;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:         PH_HEADER,
    block_index:   '0,
    stream_offset: '0,
    data_left:     '0,
    pad_left:      '0,
    all_zero:      1'b1,
    mode_acc:      '0,
    mode_open:     1'b1,
    size_acc:      '0,
    size_open:     1'b1,
    magic_match:   1'b1,
    type_code:     '0,
    name_len:      '0,
    name_trail:    '0,
    name_done:     1'b0,
    prefix_len:    '0,
    prefix_trail:  '0,
    prefix_done:   1'b0
  };

  // Expected "ustar" character at magic offset k
  function automatic logic [7:0] magic_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = 8'h75;  // u
      3'd1:    c = 8'h73;  // s
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h61;  // a
      3'd4:    c = 8'h72;  // r
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // Reset the per-header accumulators, keep the stream-level state
  function automatic parse_state_t clear_header(input parse_state_t s);
    parse_state_t r;
    r = s;
    r.block_index  = STATE_RESET.block_index;
    r.all_zero     = STATE_RESET.all_zero;
    r.mode_acc     = STATE_RESET.mode_acc;
    r.mode_open    = STATE_RESET.mode_open;
    r.size_acc     = STATE_RESET.size_acc;
    r.size_open    = STATE_RESET.size_open;
    r.magic_match  = STATE_RESET.magic_match;
    r.type_code    = STATE_RESET.type_code;
    r.name_len     = STATE_RESET.name_len;
    r.name_trail   = STATE_RESET.name_trail;
    r.name_done    = STATE_RESET.name_done;
    r.prefix_len   = STATE_RESET.prefix_len;
    r.prefix_trail = STATE_RESET.prefix_trail;
    r.prefix_done  = STATE_RESET.prefix_done;
    return r;
  endfunction

endpackage

### design/tar_header_stream_parser.sv
// Tar header stream parser: takes one archive byte per transfer and emits entry descriptors,
// entry data bytes, and a corrupt-header marker. Depends on tar_hsp_pkg.
//
// Throughput is one archive byte per clock while item_ready is high. Each byte updates the
// parse state in the cycle it is accepted; its result (if any) is registered in the output
// register, or in the one-entry skid register behind it while the output register is full.
// The skid keeps input transfers flowing while the result channel stalls; item_ready drops
// only when both hold a result. Header bytes but a block's last, padding bytes and bytes after
// a corrupt header produce no result. Restart clears all parse state before its byte is handled.
module tar_header_stream_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  tar_hsp_pkg::item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output tar_hsp_pkg::result_t result
);
  import tar_hsp_pkg::*;

  parse_state_t        st;
  parse_state_t        st_next;
  parse_state_t        cur;
  result_t             res;
  logic                res_valid;
  logic                accept;
  logic [7:0]          b;
  logic [IDX_BITS-1:0] idx;
  logic [IDX_BITS-1:0] mag_off;
  logic                digit;

  // Header finish terms
  logic [7:0]           plen;
  logic [7:0]           ptrail;
  logic [7:0]           total;
  logic [7:0]           trail;
  logic [7:0]           tcode;
  logic [1:0]           etype;
  logic [SIZE_BITS-1:0] dl_dec;
  logic [IDX_BITS-1:0]  pl_dec;

  // Output register and skid register
  logic    out_v;
  result_t out_d;
  logic    skid_v;
  result_t skid_d;
  logic    out_fire;

  assign item_ready   = !skid_v;
  assign accept       = item_valid && item_ready;
  assign result_valid = out_v;
  assign result       = out_d;
  assign out_fire     = out_v && result_ready;

  // Restart clears everything before the byte is absorbed
  assign cur     = item.restart ? STATE_RESET : st;
  assign b       = item.archive_byte;
  assign idx     = cur.block_index;
  assign mag_off = idx - MAGIC_BEG;
  assign digit   = (b >= CH_ZERO) && (b <= CH_SEVEN);
  assign dl_dec  = (cur.data_left != '0) ? cur.data_left - 1'b1 : cur.data_left;
  assign pl_dec  = (cur.pad_left != '0) ? cur.pad_left - 1'b1 : cur.pad_left;

  // Name/prefix length with trailing slashes and type classification
  always_comb begin
    plen   = cur.magic_match ? cur.prefix_len : 8'd0;
    ptrail = cur.magic_match ? cur.prefix_trail : 8'd0;
    total  = plen + {1'b0, cur.name_len};
    if (cur.name_len == '0) begin
      trail = ptrail;
    end else if (cur.name_trail == cur.name_len) begin
      trail = {1'b0, cur.name_len} + ptrail;
    end else begin
      trail = {1'b0, cur.name_trail};
    end
    tcode = (cur.type_code == CH_NUL) ? TF_FILE : cur.type_code;
    // Legacy archives mark directories by a trailing slash only
    if (trail != 8'd0 && !cur.magic_match && tcode == TF_FILE) begin
      tcode = TF_DIR;
    end
    priority if (tcode == TF_FILE) begin
      etype = ET_FILE;
    end else if (tcode == TF_DIR) begin
      etype = ET_DIR;
    end else if (tcode == TF_SYMLINK) begin
      etype = ET_SYMLINK;
    end else begin
      etype = ET_UNKNOWN;
    end
  end

  // Per-byte state update and result
  always_comb begin
    st_next   = cur;
    res       = '0;
    res_valid = 1'b0;
    st_next.stream_offset = cur.stream_offset + 1'b1;
    unique case (cur.phase)
      PH_HEADER: begin
        if (b != CH_NUL) begin
          st_next.all_zero = 1'b0;
        end
        if (idx < NAME_END && !cur.name_done) begin
          if (b == CH_NUL) begin
            st_next.name_done = 1'b1;
          end else begin
            st_next.name_len   = cur.name_len + 1'b1;
            st_next.name_trail = (b == CH_SLASH) ? cur.name_trail + 1'b1 : 7'd0;
          end
        end
        if (idx >= MODE_BEG && idx < MODE_END) begin
          if (cur.mode_open && digit) begin
            st_next.mode_acc = {cur.mode_acc[12:0], b[2:0]};
          end else begin
            st_next.mode_open = 1'b0;
          end
        end
        if (idx >= SIZE_BEG && idx < SIZE_END) begin
          if (cur.size_open && digit) begin
            st_next.size_acc = {cur.size_acc[SIZE_BITS-4:0], b[2:0]};
          end else begin
            st_next.size_open = 1'b0;
          end
        end
        if (idx == TYPE_POS) begin
          st_next.type_code = b;
        end
        if (idx >= MAGIC_BEG && idx < MAGIC_VER && b != magic_char(mag_off[2:0])) begin
          st_next.magic_match = 1'b0;
        end
        if (idx == MAGIC_VER && b != CH_SPACE && b != CH_NUL) begin
          st_next.magic_match = 1'b0;
        end
        if (idx >= PREFIX_BEG && idx < PREFIX_END && !cur.prefix_done) begin
          if (b == CH_NUL) begin
            st_next.prefix_done = 1'b1;
          end else begin
            st_next.prefix_len   = cur.prefix_len + 1'b1;
            st_next.prefix_trail = (b == CH_SLASH) ? cur.prefix_trail + 1'b1 : 8'd0;
          end
        end
        // Last byte of the block closes the header
        if (idx == LAST_IDX) begin
          if (st_next.all_zero) begin
            st_next = clear_header(st_next);
          end else if (total == 8'd0) begin
            res_valid     = 1'b1;
            res.kind      = KIND_CORRUPT;
            st_next.phase = PH_HALT;
            st_next       = clear_header(st_next);
          end else begin
            res_valid        = 1'b1;
            res.kind         = KIND_DESC;
            res.entry_type   = etype;
            res.ustar_flag   = cur.magic_match;
            res.mode_bits    = cur.mode_acc;
            res.file_size    = cur.size_acc;
            res.data_offset  = st_next.stream_offset;
            res.name_length  = total - trail;
            st_next.data_left = cur.size_acc;
            st_next.pad_left  = IDX_BITS'(0) - cur.size_acc[IDX_BITS-1:0];
            st_next.phase     = (cur.size_acc != '0) ? PH_DATA : PH_HEADER;
            st_next           = clear_header(st_next);
          end
        end else begin
          st_next.block_index = idx + 1'b1;
        end
      end
      PH_DATA: begin
        res_valid         = 1'b1;
        res.kind          = KIND_DATA;
        res.data_byte     = b;
        res.last_data     = (cur.data_left == SIZE_BITS'(1));
        st_next.data_left = dl_dec;
        if (dl_dec == '0) begin
          st_next.phase = (cur.pad_left != '0) ? PH_PAD : PH_HEADER;
        end
      end
      PH_PAD: begin
        st_next.pad_left = pl_dec;
        if (pl_dec == '0) begin
          st_next.phase = PH_HEADER;
        end
      end
      PH_HALT: begin
        st_next.stream_offset = cur.stream_offset + 1'b1;
      end
      default: begin
        st_next = cur;
      end
    endcase
  end

  // Parse state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_fire) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      if (!out_v) begin
        out_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_v) begin
        out_d <= skid_d;
      end else if (accept && res_valid) begin
        out_d <= res;
      end
    end else if (accept && res_valid) begin
      if (!out_v) begin
        out_d <= res;
      end else begin
        skid_d <= res;
      end
    end
  end

  // Skid holds a result only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) skid_v |-> out_v)
    else $error("skid register full while output register empty");

  // Data phase always has bytes left to deliver
  a_data_left: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_DATA |-> st.data_left != '0)
    else $error("data phase with no bytes left");

  // Pad phase always has padding left to skip
  a_pad_left: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_PAD |-> st.pad_left != '0)
    else $error("pad phase with no padding left");

  // Only descriptors carry an offset
  a_offset_desc: assert property (@(posedge clk) disable iff (rst)
    out_v && out_d.kind != KIND_DESC |-> out_d.data_offset == '0)
    else $error("non-descriptor result carries an offset");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for tar_header_stream_parser: directed and random archive streams.
// Holds a bit-level model of the parser and checks every result transfer.
// Depends on tar_hsp_pkg and the tar_header_stream_parser RTL.
module testbench;
  import tar_hsp_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int BODY_CAP     = 4096;

  // Type flags not named by the package
  localparam logic [7:0] TF_HARDLINK = 8'h31;
  localparam logic [7:0] TF_CHARDEV  = 8'h33;
  localparam logic [7:0] TF_CONTIG   = 8'h37;
  localparam logic [7:0] TF_JUNK     = 8'hFF;

  localparam logic [39:0] USTAR_WORD = "ustar";

  typedef enum int {
    MAGIC_NONE,
    MAGIC_NUL_TERM,
    MAGIC_SPACE_TERM,
    MAGIC_BROKEN
  } magic_form_t;

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  tar_header_stream_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          error_count   = 0;
  int          idle_cycles   = 0;
  logic        restart_next  = 1'b0;

  // Outputs the parser owes, oldest first
  result_t     parser_outputs_due [$];
  result_t     oldest_due;

  // Header block under construction
  logic [7:0]  hdr_block [512];

  // Model of the parse state
  phase_t                 parse_phase;
  logic [IDX_BITS-1:0]    hdr_pos;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [SIZE_BITS-1:0]   data_remaining;
  logic [IDX_BITS-1:0]    pad_remaining;
  logic                   block_blank;
  logic [15:0]            mode_value;
  logic                   mode_scanning;
  logic [SIZE_BITS-1:0]   size_value;
  logic                   size_scanning;
  logic                   magic_good;
  logic [7:0]             type_flag;
  logic [6:0]             name_chars;
  logic [6:0]             name_slashes;
  logic                   name_closed;
  logic [7:0]             prefix_chars;
  logic [7:0]             prefix_slashes;
  logic                   prefix_closed;

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function automatic void clear_accumulators();
    hdr_pos        = '0;
    block_blank    = 1'b1;
    mode_value     = '0;
    mode_scanning  = 1'b1;
    size_value     = '0;
    size_scanning  = 1'b1;
    magic_good     = 1'b1;
    type_flag      = CH_NUL;
    name_chars     = '0;
    name_slashes   = '0;
    name_closed    = 1'b0;
    prefix_chars   = '0;
    prefix_slashes = '0;
    prefix_closed  = 1'b0;
  endfunction

  function automatic void reset_parse_model();
    parse_phase    = PH_HEADER;
    byte_offset    = '0;
    data_remaining = '0;
    pad_remaining  = '0;
    clear_accumulators();
  endfunction

  // Last header byte: emit descriptor or corrupt marker if not blank, pick the next phase
  function automatic void close_header();
    logic        ustar;
    int unsigned pre_len;
    int unsigned pre_trail;
    int unsigned total;
    int unsigned trail;
    logic [7:0]  flag;
    result_t     rec;
    ustar     = magic_good;
    pre_len   = ustar ? 32'(prefix_chars) : 0;
    pre_trail = ustar ? 32'(prefix_slashes) : 0;
    total     = pre_len + 32'(name_chars);
    rec       = '0;
    if (!block_blank) begin
      if (total == 0) begin
        rec.kind    = KIND_CORRUPT;
        parse_phase = PH_HALT;
      end else begin
        if (name_chars == 0) trail = pre_trail;
        else if (name_slashes == name_chars) trail = 32'(name_chars) + pre_trail;
        else trail = 32'(name_slashes);
        flag = (type_flag == CH_NUL) ? TF_FILE : type_flag;
        // old-style archives mark directories with a trailing slash
        if (trail > 0 && !ustar && flag == TF_FILE) flag = TF_DIR;
        case (flag)
          TF_FILE:    rec.entry_type = ET_FILE;
          TF_DIR:     rec.entry_type = ET_DIR;
          TF_SYMLINK: rec.entry_type = ET_SYMLINK;
          default:    rec.entry_type = ET_UNKNOWN;
        endcase
        rec.kind        = KIND_DESC;
        rec.ustar_flag  = ustar;
        rec.mode_bits   = mode_value;
        rec.file_size   = size_value;
        rec.data_offset = byte_offset;
        rec.name_length = 8'(total - trail);
        data_remaining  = size_value;
        pad_remaining   = 9'd0 - size_value[8:0];
        parse_phase     = (size_value != 0) ? PH_DATA : PH_HEADER;
      end
      parser_outputs_due.push_back(rec);
    end
    clear_accumulators();
  endfunction

  // One accepted archive byte
  function automatic void parse_archive_byte(input logic [7:0] b, input logic rs);
    logic    digit;
    int      k;
    result_t rec;
    if (rs) reset_parse_model();
    byte_offset = byte_offset + 1'b1;
    digit = (b >= CH_ZERO) && (b <= CH_SEVEN);
    case (parse_phase)
      PH_HEADER: begin
        if (b != CH_NUL) block_blank = 1'b0;
        if (hdr_pos < NAME_END && !name_closed) begin
          if (b == CH_NUL) name_closed = 1'b1;
          else begin
            name_chars   = name_chars + 1'b1;
            name_slashes = (b == CH_SLASH) ? name_slashes + 1'b1 : 7'd0;
          end
        end
        if (hdr_pos >= MODE_BEG && hdr_pos < MODE_END) begin
          if (mode_scanning && digit) mode_value = {mode_value[12:0], b[2:0]};
          else mode_scanning = 1'b0;
        end
        if (hdr_pos >= SIZE_BEG && hdr_pos < SIZE_END) begin
          if (size_scanning && digit) size_value = {size_value[SIZE_BITS-4:0], b[2:0]};
          else size_scanning = 1'b0;
        end
        if (hdr_pos == TYPE_POS) type_flag = b;
        if (hdr_pos >= MAGIC_BEG && hdr_pos < MAGIC_VER) begin
          k = int'(hdr_pos - MAGIC_BEG);
          if (b != USTAR_WORD[8*(4-k) +: 8]) magic_good = 1'b0;
        end
        if (hdr_pos == MAGIC_VER && b != CH_SPACE && b != CH_NUL) magic_good = 1'b0;
        if (hdr_pos >= PREFIX_BEG && hdr_pos < PREFIX_END && !prefix_closed) begin
          if (b == CH_NUL) prefix_closed = 1'b1;
          else begin
            prefix_chars   = prefix_chars + 1'b1;
            prefix_slashes = (b == CH_SLASH) ? prefix_slashes + 1'b1 : 8'd0;
          end
        end
        if (hdr_pos == LAST_IDX) close_header();
        else hdr_pos = hdr_pos + 1'b1;
      end
      PH_DATA: begin
        rec           = '0;
        rec.kind      = KIND_DATA;
        rec.data_byte = b;
        rec.last_data = (data_remaining == 1);
        parser_outputs_due.push_back(rec);
        if (data_remaining != 0) data_remaining = data_remaining - 1'b1;
        if (data_remaining == 0) parse_phase = (pad_remaining != 0) ? PH_PAD : PH_HEADER;
      end
      PH_PAD: begin
        if (pad_remaining != 0) pad_remaining = pad_remaining - 1'b1;
        if (pad_remaining == 0) parse_phase = PH_HEADER;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, checking, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (parser_outputs_due.size() == 0) begin
        $error("result transfer with nothing due: kind %0d", result.kind);
        error_count++;
      end else begin
        oldest_due = parser_outputs_due.pop_front();
        check_field("kind",        64'(oldest_due.kind),        64'(result.kind));
        check_field("data_byte",   64'(oldest_due.data_byte),   64'(result.data_byte));
        check_field("last_data",   64'(oldest_due.last_data),   64'(result.last_data));
        check_field("entry_type",  64'(oldest_due.entry_type),  64'(result.entry_type));
        check_field("ustar_flag",  64'(oldest_due.ustar_flag),  64'(result.ustar_flag));
        check_field("mode_bits",   64'(oldest_due.mode_bits),   64'(result.mode_bits));
        check_field("file_size",   64'(oldest_due.file_size),   64'(result.file_size));
        check_field("data_offset", 64'(oldest_due.data_offset), 64'(result.data_offset));
        check_field("name_length", 64'(oldest_due.name_length), 64'(result.name_length));
      end
    end
  end

  // Ends the run when no transfer happens on either channel for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // One byte transfer; valid is only dropped when a gap is taken
  task automatic send_byte(input logic [7:0] value);
    logic rs;
    rs = restart_next;
    restart_next = 1'b0;
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    item       <= '{archive_byte: value, restart: rs};
    do @(posedge clk); while (!item_ready);
    parse_archive_byte(value, rs);
  endtask

  task automatic blank_block();
    foreach (hdr_block[i]) hdr_block[i] = CH_NUL;
  endtask

  task automatic put_text(input int pos, input string s);
    for (int i = 0; i < s.len(); i++) hdr_block[pos + i] = s[i];
  endtask

  task automatic fill_text(input int pos, input int len, input logic [7:0] ch);
    for (int i = 0; i < len; i++) hdr_block[pos + i] = ch;
  endtask

  task automatic put_magic(input magic_form_t form);
    case (form)
      MAGIC_NUL_TERM: begin
        put_text(MAGIC_BEG, "ustar");
        hdr_block[MAGIC_VER] = CH_NUL;
        put_text(MAGIC_VER + 1, "00");
      end
      MAGIC_SPACE_TERM: begin
        put_text(MAGIC_BEG, "ustar  ");
        hdr_block[MAGIC_VER + 2] = CH_NUL;
      end
      MAGIC_BROKEN: put_text(MAGIC_BEG, "ustor");
      default: ;
    endcase
  endtask

  task automatic build_header(input string name, input string prefix, input magic_form_t form,
                              input logic [7:0] flag, input int unsigned mode,
                              input logic [SIZE_BITS-1:0] nbytes);
    blank_block();
    put_text(0, name);
    put_text(MODE_BEG, $sformatf("%07o", mode));
    put_text(SIZE_BEG, $sformatf("%011o", nbytes));
    hdr_block[TYPE_POS] = flag;
    put_magic(form);
    put_text(PREFIX_BEG, prefix);
  endtask

  task automatic send_header(input int count);
    for (int i = 0; i < count; i++) send_byte(hdr_block[i]);
  endtask

  // Data and padding bytes until the parser is back looking for a header or cap bytes are sent
  task automatic send_body(input int cap);
    int n;
    n = 0;
    while ((parse_phase == PH_DATA || parse_phase == PH_PAD) && n < cap) begin
      send_byte(8'($urandom_range(255)));
      n++;
    end
  endtask

  task automatic send_entry(input string name, input string prefix, input magic_form_t form,
                            input logic [7:0] flag, input int unsigned mode,
                            input logic [SIZE_BITS-1:0] nbytes);
    build_header(name, prefix, form, flag, mode, nbytes);
    send_header(512);
    send_body(BODY_CAP);
  endtask

  function automatic logic [7:0] random_name_char();
    logic [7:0] c;
    c = 8'($urandom_range(255, 1));
    if ($urandom_range(3) == 0) c = CH_SLASH;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_entries();
    restart_next = 1'b1;
    send_entry("dir/file.txt", "", MAGIC_NUL_TERM, TF_FILE, 'o644, 5);
    send_entry("a", "", MAGIC_SPACE_TERM, CH_NUL, 'o755, 512);
    // prefix is ignored without the magic
    send_entry("b.bin", "pre", MAGIC_NONE, TF_FILE, 'o600, 1);
  endtask

  task automatic test_zero_blocks();
    blank_block();
    send_header(512);
    send_entry("d/", "", MAGIC_NUL_TERM, TF_DIR, 'o755, 0);
    send_entry("empty", "", MAGIC_SPACE_TERM, TF_FILE, 'o644, 0);
    blank_block();
    send_header(512);
  endtask

  task automatic test_name_forms();
    // all slashes, old style: length drops to zero, becomes a directory
    send_entry("///", "", MAGIC_NONE, TF_FILE, 'o755, 0);
    send_entry("x/", "", MAGIC_NUL_TERM, TF_FILE, 'o644, 3);
    send_entry("", "p/q", MAGIC_NUL_TERM, TF_FILE, 'o644, 2);
    send_entry("//", "pp//", MAGIC_SPACE_TERM, TF_DIR, 'o755, 0);
    send_entry("abc/", "", MAGIC_NONE, CH_NUL, 'o755, 0);
    // longest name and prefix, no terminators
    build_header("", "", MAGIC_NUL_TERM, TF_FILE, 'o644, 7);
    fill_text(0, 100, "n");
    hdr_block[99] = CH_SLASH;
    fill_text(PREFIX_BEG, 155, "p");
    send_header(512);
    send_body(BODY_CAP);
  endtask

  task automatic test_type_codes();
    logic [7:0] odd_flags [5] = '{TF_HARDLINK, TF_SYMLINK, TF_CHARDEV, TF_CONTIG, TF_JUNK};
    foreach (odd_flags[i]) send_entry($sformatf("t%0d", i), "", MAGIC_NUL_TERM, odd_flags[i],
                                      'o644, 0);
    // trailing slash on an old-style link does not make it a directory
    send_entry("ln/", "", MAGIC_NONE, TF_SYMLINK, 'o777, 0);
  endtask

  task automatic test_octal_fields();
    // eight mode digits overflow the 16-bit value
    build_header("m", "", MAGIC_NUL_TERM, TF_FILE, 0, 1);
    fill_text(MODE_BEG, 8, CH_SEVEN);
    send_header(512);
    send_body(BODY_CAP);
    // leading space ends the mode, non-digit ends the size early
    build_header("s", "", MAGIC_SPACE_TERM, TF_FILE, 'o644, 0);
    hdr_block[MODE_BEG] = CH_SPACE;
    put_text(SIZE_BEG, "12x7");
    send_header(512);
    send_body(BODY_CAP);
    build_header("q", "", MAGIC_BROKEN, TF_FILE, 'o1777, 0);
    put_text(SIZE_BEG, "1899");
    send_header(512);
    send_body(BODY_CAP);
  endtask

  task automatic test_corrupt_header();
    send_entry("", "", MAGIC_NUL_TERM, TF_FILE, 'o644, 5);
    repeat (600) send_byte(8'($urandom_range(255)));
    restart_next = 1'b1;
    send_entry("", "lost/prefix", MAGIC_NONE, TF_FILE, 'o644, 0);
    repeat (20) send_byte(8'($urandom_range(255)));
    restart_next = 1'b1;
    send_entry("back", "", MAGIC_NUL_TERM, TF_FILE, 'o644, 9);
  endtask

  task automatic test_restart_midway();
    build_header("cut", "", MAGIC_NUL_TERM, TF_FILE, 'o644, 100);
    send_header(200);
    restart_next = 1'b1;
    // widest size field: never finishes, cut short by a restart
    build_header("huge", "", MAGIC_SPACE_TERM, TF_FILE, 'o644, 0);
    fill_text(SIZE_BEG, 12, CH_SEVEN);
    send_header(512);
    send_body(300);
    restart_next = 1'b1;
    send_entry("after", "", MAGIC_NUL_TERM, TF_FILE, 'o644, 9);
  endtask

  // Mostly well-formed headers with random content, some noise-filled
  task automatic make_random_header();
    int unsigned             sel;
    int unsigned             len;
    logic [SIZE_BITS-1:0]    nbytes;
    if ($urandom_range(19) == 0) begin
      blank_block();
      return;
    end
    if ($urandom_range(3) == 0) foreach (hdr_block[i]) hdr_block[i] = 8'($urandom_range(255));
    else blank_block();
    // name, with whatever follows the terminator left in place
    sel = $urandom_range(19);
    len = (sel == 0) ? 0 : (sel == 1) ? 100 : $urandom_range(40, 1);
    for (int i = 0; i < len; i++) hdr_block[i] = random_name_char();
    if (len < 100) hdr_block[len] = CH_NUL;
    // mode
    sel = $urandom_range(9);
    if (sel < 8) put_text(MODE_BEG, $sformatf("%07o", $urandom_range('o7777)));
    else if (sel == 8) for (int i = 0; i < 8; i++)
      hdr_block[MODE_BEG + i] = CH_ZERO + 8'($urandom_range(7));
    // size, mostly small
    sel = $urandom_range(19);
    if (sel < 3) nbytes = 0;
    else if (sel < 5) nbytes = SIZE_BITS'(512 * $urandom_range(3, 1));
    else if (sel == 5) nbytes = SIZE_BITS'($urandom_range(2000));
    else nbytes = SIZE_BITS'($urandom_range(600, 1));
    if (sel < 19) put_text(SIZE_BEG, $sformatf("%011o", nbytes));
    // type flag
    case ($urandom_range(7))
      0:       hdr_block[TYPE_POS] = CH_NUL;
      1, 2:    hdr_block[TYPE_POS] = TF_FILE;
      3:       hdr_block[TYPE_POS] = TF_DIR;
      4:       hdr_block[TYPE_POS] = TF_SYMLINK;
      5:       hdr_block[TYPE_POS] = TF_HARDLINK;
      6:       hdr_block[TYPE_POS] = 8'($urandom_range(255));
      default: ;
    endcase
    // magic
    sel = $urandom_range(9);
    if (sel < 4) put_magic(MAGIC_NUL_TERM);
    else if (sel < 7) put_magic(MAGIC_SPACE_TERM);
    else if (sel == 7) put_magic(MAGIC_BROKEN);
    else if (sel == 8) fill_text(MAGIC_BEG, 8, CH_NUL);
    // prefix
    if ($urandom_range(1) == 1) begin
      len = ($urandom_range(9) == 0) ? 155 : $urandom_range(30);
      for (int i = 0; i < len; i++) hdr_block[PREFIX_BEG + i] = random_name_char();
      if (len < 155) hdr_block[PREFIX_BEG + len] = CH_NUL;
    end
  endtask

  task automatic test_random_archives(input int n_headers);
    int cut;
    restart_next = 1'b1;
    repeat (n_headers) begin
      make_random_header();
      cut = ($urandom_range(19) == 0) ? $urandom_range(511) : 512;
      send_header(cut);
      if (cut < 512) restart_next = 1'b1;
      else if (parse_phase == PH_HALT) begin
        repeat ($urandom_range(40)) send_byte(8'($urandom_range(255)));
        restart_next = 1'b1;
      end else begin
        send_body(($urandom_range(15) == 0) ? $urandom_range(600) : BODY_CAP);
        if (parse_phase != PH_HEADER) restart_next = 1'b1;
      end
      // occasionally start a fresh archive anyway
      if ($urandom_range(9) == 0) restart_next = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_parse_model();
    send_idle_pct = 22;
    recv_idle_pct = 68;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_basic_entries();
    test_zero_blocks();
    test_name_forms();
    test_type_codes();
    test_octal_fields();
    test_corrupt_header();
    test_restart_midway();

    test_random_archives(12);
    send_idle_pct = 68;
    recv_idle_pct = 22;
    test_random_archives(12);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_archives(12);

    item_valid <= 1'b0;
    while (parser_outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
